[design/ypvm_pkg.sv]
// ypvm_pkg: shared types, constants and fixed-point helpers for the yaw/pitch view matrix.
// No dependencies.
package ypvm_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;

    // op codes
    localparam logic [1:0] OP_PITCH = 2'd0;
    localparam logic [1:0] OP_YAW   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_TX = 2'd0;
    localparam logic [1:0] REG_TY = 2'd1;
    localparam logic [1:0] REG_TZ = 2'd2;

    localparam logic signed [31:0] QONE = 32'sh4000_0000;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] YAW_RESET = ANGLE_BITS'(3) << (ANGLE_BITS - 2);

    // Q30 polynomial coefficients, lowest degree first
    localparam logic signed [31:0] POLY_K0 = 32'sd1686629713;
    localparam logic signed [31:0] POLY_K1 = -32'sd693598668;
    localparam logic signed [31:0] POLY_K2 = 32'sd85569306;
    localparam logic signed [31:0] POLY_K3 = -32'sd5026994;
    localparam logic signed [31:0] POLY_K4 = 32'sd172272;

    typedef struct packed {
        logic [1:0]  op;
        logic signed [15:0] angle_delta;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  column_index;
        logic signed [31:0] row0_value;
        logic signed [31:0] row1_value;
        logic signed [31:0] row2_value;
        logic        last_column;
        logic        degenerate;
    } t_out_beat;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg_beat;

    // controller -> datapath
    typedef struct packed {
        logic       load;       // capture beat, update angle
        logic       trig_start; // begin sin of angle slot
        logic [1:0] trig_sel;   // 0 sp,1 cp,2 sy,3 cy
        logic       trig_step;  // one Horner step or the final x product
        logic       trig_fin;   // finish and store
        logic       mul_step;   // one product step
        logic [3:0] mul_sel;
    } t_cmd;

    // rounded shift right, half away from zero
    function automatic logic signed [63:0] rsr(input logic signed [63:0] v,
                                               input int unsigned k);
        logic [63:0] m;
        begin
            m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
            m = (m + (64'd1 << (k - 1))) >> k;
            rsr = v[63] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)        sat32 = 32'sh7FFF_FFFF;
            else if (v < -64'sd2147483648)  sat32 = 32'sh8000_0000;
            else                            sat32 = v[31:0];
        end
    endfunction

endpackage

[design/yaw_pitch_view_matrix.sv]
// Yaw/pitch look-at view matrix. Each accepted input beat optionally steps pitch
// or yaw, then a sequencer rebuilds the frame: four sines through one shared
// 32x32 Q30 multiplier (fold and x^2, four Horner steps, final x product, clamp),
// four cross-product terms, three dot-product terms, then four output beats,
// columns 0..3. The trig pass on the shared multiplier takes most of the time
// from one accept to the next when the output is not stalled. A stalled output
// holds the sequencer in its emit phase. One item at a time; the output register
// lets the last column wait while the next beat is accepted.
// Depends on ypvm_pkg, ypvm_ctrl, ypvm_dp.
module yaw_pitch_view_matrix import ypvm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in_beat i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out_beat o_out_data,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  t_cfg_beat i_cfg_data
);
    t_cmd cmd;
    logic emit, dot_step;
    logic [1:0] col, dot_sel;
    t_out_beat beat;
    logic r_valid;
    t_out_beat r_data;
    logic busy;

    assign busy = r_valid && !i_out_ready;
    assign o_cfg_ready = 1'b1;

    ypvm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready,
        .i_out_busy(busy), .o_emit(emit), .o_col(col), .o_cmd(cmd),
        .o_dot_step(dot_step), .o_dot_sel(dot_sel)
    );

    ypvm_dp u_dp (
        .i_clk, .i_rst_n, .i_beat(i_in_data),
        .i_cfg_we(i_cfg_valid), .i_cfg(i_cfg_data),
        .i_cmd(cmd), .i_dot_step(dot_step), .i_dot_sel(dot_sel),
        .i_col(col), .o_beat(beat)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (emit) r_valid <= 1'b1;
        else if (i_out_ready) r_valid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (emit) r_data <= beat;
    end
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !busy) else $error("output beat overwritten");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_out_data))
        else $error("stalled beat changed");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !o_in_ready) else $error("input taken mid item");
`endif
endmodule

[design/ypvm_ctrl.sv]
// ypvm_ctrl: sequencer for trig, products, dot products and column output.
// Depends on ypvm_pkg.
module ypvm_ctrl import ypvm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_busy,   // output register full and not draining
    output logic o_emit,
    output logic [1:0] o_col,
    output t_cmd o_cmd,
    output logic o_dot_step,
    output logic [1:0] o_dot_sel
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TRIG = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DOT  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_slot, n_slot;
    logic [3:0] r_mul, n_mul;
    logic [1:0] r_col, n_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_slot  <= '0;
            r_mul   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_slot  <= n_slot;
            r_mul   <= n_mul;
            r_col   <= n_col;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_slot  = r_slot;
        n_mul   = r_mul;
        n_col   = r_col;
        o_in_ready = 1'b0;
        o_emit  = 1'b0;
        o_col   = r_col;
        o_cmd   = '0;
        o_cmd.trig_sel = r_slot;
        o_cmd.mul_sel  = r_mul;
        o_dot_step = 1'b0;
        o_dot_sel  = r_col;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_TRIG;
                    n_slot  = '0;
                    n_step  = '0;
                end
            end
            S_TRIG: begin
                // step 0 start, 1..5 Horner + final multiply, 6 finish
                if (r_step == 3'd0)      o_cmd.trig_start = 1'b1;
                else if (r_step == 3'd6) o_cmd.trig_fin   = 1'b1;
                else                     o_cmd.trig_step  = 1'b1;
                if (r_step == 3'd6) begin
                    n_step = '0;
                    n_slot = r_slot + 2'd1;
                    if (r_slot == 2'd3) begin
                        n_state = S_MUL;
                        n_mul   = '0;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_mul = r_mul + 4'd1;
                if (r_mul == 4'd3) begin
                    n_state = S_DOT;
                    n_col   = '0;
                    n_step  = '0;
                end
            end
            S_DOT: begin
                // three dot products, one term per cycle
                o_dot_step = 1'b1;
                o_dot_sel  = r_step[1:0];
                n_step = r_step + 3'd1;
                if (r_step == 3'd2) begin
                    n_state = S_EMIT;
                    n_step  = '0;
                    n_col   = '0;
                end
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_emit = 1'b1;
                    n_col  = r_col + 2'd1;
                    if (r_col == 2'd3) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_emit_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> r_state == S_EMIT) else $error("emit outside emit state");
    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && r_col == 2'd3) |=> r_state == S_IDLE) else $error("no idle after column 3");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready while busy");
`endif
endmodule

[design/ypvm_dp.sv]
// ypvm_dp: angle registers, shared Q30 multiplier, trig, frame vectors, dot products.
// Depends on ypvm_pkg.
module ypvm_dp import ypvm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in_beat i_beat,
    input  logic i_cfg_we,
    input  t_cfg_beat i_cfg,
    input  t_cmd i_cmd,
    input  logic i_dot_step,
    input  logic [1:0] i_dot_sel,
    input  logic [1:0] i_col,
    output t_out_beat o_beat
);
    logic [ANGLE_BITS-1:0] r_pitch, r_yaw;
    logic signed [31:0] r_tx, r_ty, r_tz;
    logic signed [31:0] r_sp, r_cp, r_sy, r_cy;
    logic signed [31:0] r_x2, r_p;
    logic        r_neg;
    logic signed [31:0] r_f0, r_f2, r_u0, r_u2;
    logic [2:0]  r_h;

    // one shared multiplier: operands picked by phase
    logic signed [31:0] m_a, m_b;
    logic signed [63:0] m_p, m_q;
    assign m_p = m_a * m_b;
    assign m_q = rsr(m_p, 30);

    logic [ANGLE_BITS-1:0] ang, delta_w;
    logic [ANGLE_BITS-3:0] r_frac;
    logic [1:0] quad;
    logic [ANGLE_BITS-2:0] rf;
    logic signed [31:0] x_fold;
    logic sg_neg;
    assign sg_neg = r_cp[31];
    assign delta_w = ANGLE_BITS'($signed(i_beat.angle_delta));

    always_comb begin
        unique case (i_cmd.trig_sel)
            2'd0: ang = r_pitch;
            2'd1: ang = r_pitch + QUARTER;
            2'd2: ang = r_yaw;
            default: ang = r_yaw + QUARTER;
        endcase
        quad = ang[ANGLE_BITS-1 -: 2];
        m_a = r_p;
        m_b = r_x2;
        if (i_cmd.trig_step && r_h == 3'd4) m_b = x_fold;
        if (i_cmd.mul_step) begin
            unique case (i_cmd.mul_sel[1:0])
                2'd0: begin m_a = r_cy; m_b = r_cp; end
                2'd1: begin m_a = r_sy; m_b = r_cp; end
                2'd2: begin m_a = r_cy; m_b = r_sp; end
                default: begin m_a = r_sy; m_b = r_sp; end
            endcase
        end
        if (i_cmd.trig_start) begin
            m_a = x_fold; m_b = x_fold;
        end
    end

    // eye and dot terms
    logic signed [33:0] e0, e1, e2, ev;
    assign e0 = 34'(r_tx);
    assign e1 = 34'(r_ty) + (34'sd3 <<< FRAC_BITS);
    assign e2 = 34'(r_tz) + (34'sd6 <<< FRAC_BITS);
    logic signed [31:0] sv, uv, fv;
    logic signed [65:0] sd, ud, fd;
    logic signed [31:0] s0, s2, u1;
    assign s0 = sg_neg ? r_sy : -r_sy;
    assign s2 = sg_neg ? -r_cy : r_cy;
    assign u1 = sg_neg ? -r_cp : r_cp;
    logic signed [67:0] r_sa, r_ua, r_fa;

    always_comb begin
        unique case (i_dot_sel)
            2'd0: begin ev = e0; sv = s0; uv = r_u0; fv = r_f0; end
            2'd1: begin ev = e1; sv = '0; uv = u1; fv = r_sp; end
            default: begin ev = e2; sv = s2; uv = r_u2; fv = r_f2; end
        endcase
        sd = 66'(sv) * 66'(ev);
        ud = 66'(uv) * 66'(ev);
        fd = 66'(fv) * 66'(ev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_yaw   <= YAW_RESET;
            r_tx <= '0; r_ty <= '0; r_tz <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg.index)
                    REG_TX: r_tx <= i_cfg.data;
                    REG_TY: r_ty <= i_cfg.data;
                    REG_TZ: r_tz <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (i_beat.op == OP_PITCH)    r_pitch <= r_pitch + delta_w;
                else if (i_beat.op == OP_YAW) r_yaw   <= r_yaw + delta_w;
            end
        end
    end

    logic [ANGLE_BITS-3:0] rr;
    always_comb begin
        rr = ang[ANGLE_BITS-3:0];
        r_frac = rr;
    end

    // trig / product / dot payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_h <= '0;
        if (i_cmd.trig_start) begin
            r_neg <= quad[1];
            r_h   <= '0;
            r_p   <= POLY_K4;
        end
        if (i_cmd.trig_step) begin
            r_h <= r_h + 3'd1;
            if (r_h == 3'd4) r_p <= m_q[31:0];
            else begin
                unique case (r_h)
                    3'd0: r_p <= POLY_K3 + m_q[31:0];
                    3'd1: r_p <= POLY_K2 + m_q[31:0];
                    3'd2: r_p <= POLY_K1 + m_q[31:0];
                    default: r_p <= POLY_K0 + m_q[31:0];
                endcase
            end
        end
        if (i_cmd.mul_step) begin
            unique case (i_cmd.mul_sel[1:0])
                2'd0: r_f0 <= m_q[31:0];
                2'd1: r_f2 <= m_q[31:0];
                2'd2: r_u0 <= sg_neg ? m_q[31:0] : -m_q[31:0];
                default: r_u2 <= sg_neg ? m_q[31:0] : -m_q[31:0];
            endcase
        end
        if (i_dot_step) begin
            if (i_dot_sel == 2'd0) begin
                r_sa <= 68'(sd); r_ua <= 68'(ud); r_fa <= 68'(fd);
            end else begin
                r_sa <= r_sa + 68'(sd); r_ua <= r_ua + 68'(ud); r_fa <= r_fa + 68'(fd);
            end
        end
    end

    // clamped, signed sine results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0; r_cp <= '0; r_sy <= '0; r_cy <= '0;
        end else if (i_cmd.trig_fin) begin
            logic signed [31:0] v;
            v = r_p;
            if (v < 0) v = '0;
            if (v > QONE) v = QONE;
            if (r_neg) v = -v;
            unique case (i_cmd.trig_sel)
                2'd0: r_sp <= v;
                2'd1: r_cp <= v;
                2'd2: r_sy <= v;
                default: r_cy <= v;
            endcase
        end
    end

    // folded angle and Q30 x of the current slot; the angle holds for the whole slot
    always_comb begin
        rf = quad[0] ? ({1'b0, r_frac} == '0 ? QUARTER[ANGLE_BITS-2:0]
                        : QUARTER[ANGLE_BITS-2:0] - {1'b0, r_frac})
                     : {1'b0, r_frac};
        x_fold = 32'($unsigned(rf)) << (32 - ANGLE_BITS);
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.trig_start) r_x2 <= m_q[31:0];
    end

    // final column results
    logic signed [67:0] nsa, nua;
    logic signed [63:0] ds, du, df;
    assign nsa = -r_sa;
    assign nua = -r_ua;
    assign ds = 64'(rsr(64'(nsa), 30));
    assign du = 64'(rsr(64'(nua), 30));
    assign df = 64'(rsr(64'(r_fa), 30));

    always_comb begin
        o_beat = '0;
        o_beat.column_index = i_col;
        o_beat.last_column  = (i_col == 2'd3);
        o_beat.degenerate   = (r_cp == '0);
        unique case (i_col)
            2'd0: begin
                o_beat.row0_value = sat32(rsr(64'(s0), 30 - FRAC_BITS));
                o_beat.row1_value = sat32(rsr(64'(r_u0), 30 - FRAC_BITS));
                o_beat.row2_value = sat32(rsr(-64'(r_f0), 30 - FRAC_BITS));
            end
            2'd1: begin
                o_beat.row0_value = '0;
                o_beat.row1_value = sat32(rsr(64'(u1), 30 - FRAC_BITS));
                o_beat.row2_value = sat32(rsr(-64'(r_sp), 30 - FRAC_BITS));
            end
            2'd2: begin
                o_beat.row0_value = sat32(rsr(64'(s2), 30 - FRAC_BITS));
                o_beat.row1_value = sat32(rsr(64'(r_u2), 30 - FRAC_BITS));
                o_beat.row2_value = sat32(rsr(-64'(r_f2), 30 - FRAC_BITS));
            end
            default: begin
                o_beat.row0_value = sat32(ds);
                o_beat.row1_value = sat32(du);
                o_beat.row2_value = sat32(df);
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_trig_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.trig_fin) |-> (r_cp <= QONE && r_cp >= -QONE))
        else $error("cosine out of range");
    a_u1_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !u1[31]) else $error("camera up y negative");
    a_angles_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.load) |-> $stable(r_pitch) && $stable(r_yaw))
        else $error("angle changed without a beat");
`endif
endmodule

[sim/tb.sv]
// tb: self-checking bench for yaw_pitch_view_matrix, a table-driven directed pass
// followed by random camera steps checked against a built-in matrix predictor.
// Depends on ypvm_pkg and the yaw_pitch_view_matrix RTL.
`timescale 1ns / 100ps
module tb;
    import ypvm_pkg::*;

    localparam int RAND_ITEMS = 350;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_beat i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_beat o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    t_cfg_beat i_cfg_data = '0;

    yaw_pitch_view_matrix dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------- predictor state ----------------
    logic signed [31:0] cam_tx, cam_ty, cam_tz;
    logic [15:0] cam_pitch, cam_yaw;
    t_out_beat column_q[$];
    int err_count = 0;
    int cycles = 0;

    // rounded shift, half away from zero
    function automatic longint rnd_shift(longint v, int k);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (k - 1))) >>> k;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rnd_shift(a * b, 30);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // binary angle -> Q30 sine via quadrant fold and odd polynomial
    function automatic longint bam_sin(logic [15:0] a);
        logic [1:0] quad;
        longint r, x, x2, p, v;
        quad = a[15:14];
        r = a[13:0];
        if (quad[0]) r = 16384 - r;
        x = r <<< 16;
        x2 = qmul(x, x);
        p = 172272;
        p = -5026994 + qmul(p, x2);
        p = 85569306 + qmul(p, x2);
        p = -693598668 + qmul(p, x2);
        p = 1686629713 + qmul(p, x2);
        v = qmul(p, x);
        if (v < 0) v = 0;
        if (v > 64'sd1073741824) v = 64'sd1073741824;
        return quad[1] ? -v : v;
    endfunction

    // apply one step and queue the four view-matrix columns
    task automatic predict_view(t_in_beat b);
        longint sp, cp, sy, cy, sg, dsv, duv, dfv;
        longint f[3], s[3], u[3], e[3];
        t_out_beat c;
        if (b.op == OP_PITCH) cam_pitch = cam_pitch + 16'(b.angle_delta);
        else if (b.op == OP_YAW) cam_yaw = cam_yaw + 16'(b.angle_delta);
        sp = bam_sin(cam_pitch);
        cp = bam_sin(cam_pitch + QUARTER);
        sy = bam_sin(cam_yaw);
        cy = bam_sin(cam_yaw + QUARTER);
        sg = cp < 0 ? -1 : 1;
        f[0] = qmul(cy, cp); f[1] = sp; f[2] = qmul(sy, cp);
        s[0] = -sg * sy; s[1] = 0; s[2] = sg * cy;
        u[0] = -sg * qmul(cy, sp); u[1] = cp < 0 ? -cp : cp; u[2] = -sg * qmul(sy, sp);
        e[0] = longint'(cam_tx);
        e[1] = longint'(cam_ty) + (64'sd3 <<< 16);
        e[2] = longint'(cam_tz) + (64'sd6 <<< 16);
        for (int k = 0; k < 4; k++) begin
            c.column_index = 2'(k);
            c.last_column = (k == 3);
            c.degenerate = (cp == 0);
            if (k < 3) begin
                c.row0_value = 32'(clip32(rnd_shift(s[k], 14)));
                c.row1_value = 32'(clip32(rnd_shift(u[k], 14)));
                c.row2_value = 32'(clip32(rnd_shift(-f[k], 14)));
            end else begin
                dsv = s[0] * e[0] + s[1] * e[1] + s[2] * e[2];
                duv = u[0] * e[0] + u[1] * e[1] + u[2] * e[2];
                dfv = f[0] * e[0] + f[1] * e[1] + f[2] * e[2];
                c.row0_value = 32'(clip32(rnd_shift(-dsv, 30)));
                c.row1_value = 32'(clip32(rnd_shift(-duv, 30)));
                c.row2_value = 32'(clip32(rnd_shift(dfv, 30)));
            end
            column_q.push_back(c);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // ---------------- output side: stall pattern + checker ----------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        // receiver stalls on a slow rolling pattern, with clean stretches
        i_out_ready <= i_rst_n && (cycles[9] ? 1'b1 : ($urandom_range(0, 3) != 0));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (column_q.size() == 0) begin
                report_mismatch("unexpected beat, column", o_out_data.column_index, -1);
            end else begin
                t_out_beat w;
                w = column_q.pop_front();
                if (o_out_data.column_index !== w.column_index)
                    report_mismatch("column_index", o_out_data.column_index, w.column_index);
                if (o_out_data.row0_value !== w.row0_value)
                    report_mismatch("row0", o_out_data.row0_value, w.row0_value);
                if (o_out_data.row1_value !== w.row1_value)
                    report_mismatch("row1", o_out_data.row1_value, w.row1_value);
                if (o_out_data.row2_value !== w.row2_value)
                    report_mismatch("row2", o_out_data.row2_value, w.row2_value);
                if (o_out_data.last_column !== w.last_column)
                    report_mismatch("last_column", o_out_data.last_column, w.last_column);
                if (o_out_data.degenerate !== w.degenerate)
                    report_mismatch("degenerate", o_out_data.degenerate, w.degenerate);
            end
        end
    end

    // ---------------- input side ----------------
    task automatic send_step(logic [1:0] op, logic [15:0] delta);
        @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= '{op: op, angle_delta: delta};
        do @(posedge i_clk); while (!o_in_ready);
        predict_view('{op: op, angle_delta: delta});
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (column_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= '{index: idx, data: val};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_TX) cam_tx = val;
        else if (idx == REG_TY) cam_ty = val;
        else if (idx == REG_TZ) cam_tz = val;
    endtask

    task automatic set_eye(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        wait_drained();
        write_reg(REG_TX, x);
        write_reg(REG_TY, y);
        write_reg(REG_TZ, z);
    endtask

    // directed table: op, delta
    typedef struct {
        logic [1:0]  op;
        logic [15:0] delta;
    } t_row;

    t_row dir_tab[] = '{
        '{OP_READ, 16'h0000},       // reset pose
        '{2'd3, 16'h7FFF},          // unused op acts as read
        '{OP_PITCH, 16'h4000},      // straight up: degenerate
        '{OP_PITCH, 16'h8000},      // straight down
        '{OP_PITCH, 16'h4000},      // back to level
        '{OP_YAW, 16'h7FFF},
        '{OP_YAW, 16'h8000},
        '{OP_YAW, 16'h0001},
        '{OP_YAW, 16'hFFFF},
        '{OP_PITCH, 16'h7FFF},      // largest positive step, just short of a half circle
        '{OP_PITCH, 16'h8001},
        '{OP_PITCH, 16'h2000},
        '{OP_YAW, 16'h5555},
        '{OP_PITCH, 16'hAAAA},
        '{OP_READ, 16'h1234}
    };

    initial begin
        t_out_beat c0;
        int burst;
        cam_tx = 0; cam_ty = 0; cam_tz = 0;
        cam_pitch = 16'h0000; cam_yaw = YAW_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset pose: right (1,0,0), up (0,1,0), forward (0,0,-1); check column 0 row0
        send_step(dir_tab[0].op, dir_tab[0].delta);
        c0 = column_q[0];
        if (c0.row0_value !== 32'sh0001_0000 || c0.degenerate !== 1'b0)
            report_mismatch("reset pose column 0 row0", c0.row0_value, 32'sh0001_0000);
        for (int i = 1; i < dir_tab.size(); i++) send_step(dir_tab[i].op, dir_tab[i].delta);

        // extreme translations force column 3 saturation
        set_eye(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_step(OP_READ, 16'h0000);
        send_step(OP_YAW, 16'h2000);
        set_eye(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_step(OP_PITCH, 16'hE000);
        send_step(OP_READ, 16'h0000);
        wait_drained();
        write_reg(2'd3, 32'hDEAD_BEEF);   // out-of-range index is ignored
        send_step(OP_READ, 16'h0000);

        // random phase: bursts and gaps, a few translation settings
        for (int n = 0; n < RAND_ITEMS; ) begin
            if (n % 90 == 0)
                set_eye($urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20) << 16,
                        $urandom_range(0, 1) ? $urandom : 32'(-$urandom_range(0, 20) << 16));
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && n < RAND_ITEMS; b++, n++) begin
                logic [15:0] d;
                case ($urandom_range(0, 3))
                    0: d = 16'($urandom);
                    1: d = 16'($signed($urandom_range(0, 64)) - 32);
                    2: d = {2'($urandom_range(0, 3)), 14'd0};   // quarter turns hit poles
                    default: d = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                endcase
                send_step(2'($urandom_range(0, 3)), d);
            end
            repeat ($urandom_range(0, 40)) @(posedge i_clk);
        end
        set_eye(32'h0, 32'h0, 32'h0);
        send_step(OP_READ, 16'h0000);
        wait_drained();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
